/* hw/rtl/pbjs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the predicted burst job selector.
// No dependencies; imported by every module of the block.
package pbjs_pkg;

    localparam int KEY_W   = 24;
    localparam int MUL_W   = 27;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [KEY_W-1:0] KEY_MAX   = 24'hFFFFFF;
    localparam logic [KEY_W-1:0] Q_ONE     = 24'd256;
    localparam logic [KEY_W-1:0] EST_RESET = 24'd2560;   // 10.0 in Q16.8
    localparam logic [8:0]       WEIGHT_ONE = 9'd256;
    localparam logic [34:0]      ROUND_HALF = 35'd128;

    // floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for all x < 2^27
    localparam logic [MUL_W-1:0] DIV3_MUL   = 27'd89478486;
    localparam int               DIV3_SHIFT = 28;

    typedef enum logic [1:0] {
        KIND_REGISTER = 2'd0,
        KIND_READY    = 2'd1,
        KIND_BURST    = 2'd2,
        KIND_SELECT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        POL_ARRIVAL = 2'd0,
        POL_KNOWN   = 2'd1,
        POL_EXP     = 2'd2,
        POL_REGRESS = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        CFG_POLICY  = 2'd0,
        CFG_WEIGHT  = 2'd1,
        CFG_INITIAL = 2'd2,
        CFG_NONE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  process_id;
        logic [15:0] arr_time;
        logic [15:0] burst_length;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [3:0]       selected_id;
        logic [KEY_W-1:0] selected_key;
    } t_out_item;

    // One process table entry; hist2 is the newest burst.
    typedef struct packed {
        logic [15:0]      arrival;
        logic [15:0]      known;
        logic [15:0]      hist0;
        logic [15:0]      hist1;
        logic [15:0]      hist2;
        logic [1:0]       hcnt;
        logic [KEY_W-1:0] est;
        logic [15:0]      stamp;
    } t_rec;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

endpackage

/* hw/rtl/predicted_burst_job_selector.sv */
`timescale 1ns / 1ps
// Predicted burst job selector: process table plus shortest-job-first pick.
// Depends on pbjs_pkg, pbjs_table and pbjs_mul.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one command beat:
// register a process, mark it ready, report a completed burst, or select.
// Only a select produces an output beat (o_out_valid / i_out_stall / o_out_data).
// Commands run one at a time; o_in_stall is high while one is in progress.
// Register and mark ready step through ST_FETCH and ST_UPD; a completed burst
// adds ST_EST1 and ST_EST2 (two passes through the shared multiplier); a select
// visits ST_SCAN per entry, ST_KEY and ST_CMP per ready entry, ST_DIV for each
// ready entry that needs the regression divide by three, then ST_DONE.
// A select walks the table one entry at a time through the single read port
// of the table memory and a single key comparator; its beat is registered
// as the select leaves ST_DONE.
// The output beat sits in a register; the next command is accepted while it
// waits. A select that finishes while the previous result is still stalled
// holds in its final state until the receiver takes that beat.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) is written on each edge with
// i_cfg_we high outside reset; write it only while the block is idle.
// Reset (i_rst_n low, synchronous) empties the ready set, restores the
// register defaults and marks every table entry as never written, which reads
// as empty history with an estimate of 10.0.
module predicted_burst_job_selector
    import pbjs_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int BURST_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [32:0] BURST_MAX = (33'd1 << BURST_BITS) - 33'd1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_FETCH = 10'b0000000010,
        ST_UPD   = 10'b0000000100,
        ST_EST1  = 10'b0000001000,
        ST_EST2  = 10'b0000010000,
        ST_SCAN  = 10'b0000100000,
        ST_KEY   = 10'b0001000000,
        ST_DIV   = 10'b0010000000,
        ST_CMP   = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } t_state;

    // control registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_found, n_found;
    logic [15:0]        r_ord, n_ord;
    logic [ENTRIES-1:0] r_ready, n_ready;
    logic               r_out_vld, n_out_vld;
    t_policy            r_policy;
    logic [8:0]         r_weight;
    logic [15:0]        r_init;

    // payload registers
    t_in_item           r_item, n_item;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [KEY_W-1:0]   r_best_key, n_best_key;
    logic [15:0]        r_best_age, n_best_age;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [33:0]        r_acc, n_acc;
    t_out_item          r_out, n_out;

    // table and multiplier hookup
    t_tbl_ctl           tbl_ctl;
    logic [IDX_W-1:0]   tbl_rd_addr;
    logic [IDX_W-1:0]   tbl_wr_addr;
    t_rec               tbl_wr_data;
    t_rec               rec;
    t_mul_req           mul_req;
    logic [PROD_W-1:0]  prod;

    // datapath helpers
    logic               in_acc;
    logic               pid_ok;
    logic [IDX_W-1:0]   item_idx;
    logic [IDX_W-1:0]   scan_idx;
    logic [8:0]         w_c;
    logic [15:0]        b_sat;
    logic signed [17:0] s2;
    logic signed [19:0] s3;
    logic [34:0]        est_sum;
    logic [26:0]        est_full;
    logic [KEY_W-1:0]   est_new;
    logic [KEY_W-1:0]   div_key;
    logic [15:0]        cand_age;
    logic               better;

    pbjs_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_rd_addr (tbl_rd_addr),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .o_rd_data (rec)
    );

    pbjs_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign pid_ok   = (9'(i_in_data.process_id) < 9'(ENTRIES));
    assign item_idx = IDX_W'(r_item.process_id);
    assign scan_idx = r_idx[IDX_W-1:0];

    // weight above one acts as one; burst clipped to the configured range
    assign w_c   = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
    assign b_sat = ({17'd0, r_item.burst_length} > BURST_MAX) ?
                   BURST_MAX[15:0] : r_item.burst_length;

    // regression numerators: 2*y2 - y1 and y1 + 4*y2 - 2*y0
    assign s2 = $signed({1'b0, rec.hist2, 1'b0}) - $signed({2'b0, rec.hist1});
    assign s3 = $signed({4'b0, rec.hist1}) + $signed({2'b0, rec.hist2, 2'b0})
              - $signed({3'b0, rec.hist0, 1'b0});

    // second product of the estimate update joins the first, rounded
    assign est_sum  = 35'(r_acc) + 35'(prod[33:0]) + ROUND_HALF;
    assign est_full = est_sum[34:8];
    assign est_new  = (|est_full[26:24]) ? KEY_MAX : est_full[KEY_W-1:0];

    assign div_key  = (|prod[53:52]) ? KEY_MAX : prod[DIV3_SHIFT +: KEY_W];

    assign cand_age = r_ord - rec.stamp;
    assign better   = !r_found || (r_key < r_best_key) ||
                      ((r_key == r_best_key) && (cand_age > r_best_age));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_found    = r_found;
        n_ord      = r_ord;
        n_ready    = r_ready;
        n_item     = r_item;
        n_best     = r_best;
        n_best_key = r_best_key;
        n_best_age = r_best_age;
        n_key      = r_key;
        n_acc      = r_acc;
        n_out      = r_out;
        n_out_vld  = r_out_vld && i_out_stall;

        tbl_ctl     = '0;
        tbl_rd_addr = item_idx;
        tbl_wr_addr = item_idx;
        tbl_wr_data = rec;
        mul_req     = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_item = i_in_data;
                    if (i_in_data.kind == KIND_SELECT) begin
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_best  = '0;
                        n_state = ST_SCAN;
                    end else if (pid_ok) begin
                        n_state = ST_FETCH;
                    end
                end
            end

            ST_FETCH: begin
                tbl_ctl.rd_en = 1'b1;
                n_state       = ST_UPD;
            end

            ST_UPD: begin
                case (r_item.kind)
                    KIND_REGISTER: begin
                        tbl_ctl.wr_en    = 1'b1;
                        tbl_wr_data.hcnt = '0;
                        tbl_wr_data.est  = {r_init, 8'd0};
                        n_ready[item_idx] = 1'b0;
                        n_state          = ST_IDLE;
                    end
                    KIND_READY: begin
                        tbl_ctl.wr_en       = 1'b1;
                        tbl_wr_data.arrival = r_item.arr_time;
                        tbl_wr_data.known   = r_item.burst_length;
                        tbl_wr_data.stamp   = r_ord;
                        n_ready[item_idx]   = 1'b1;
                        n_ord               = r_ord + 16'd1;
                        n_state             = ST_IDLE;
                    end
                    default: begin
                        // w * (burst << 8)
                        mul_req.en = 1'b1;
                        mul_req.a  = MUL_W'(w_c);
                        mul_req.b  = MUL_W'({b_sat, 8'd0});
                        n_state    = ST_EST1;
                    end
                endcase
            end

            ST_EST1: begin
                // (1 - w) * old estimate
                n_acc      = prod[33:0];
                mul_req.en = 1'b1;
                mul_req.a  = MUL_W'(WEIGHT_ONE - w_c);
                mul_req.b  = MUL_W'(rec.est);
                n_state    = ST_EST2;
            end

            ST_EST2: begin
                tbl_ctl.wr_en     = 1'b1;
                tbl_wr_data.hist0 = rec.hist1;
                tbl_wr_data.hist1 = rec.hist2;
                tbl_wr_data.hist2 = b_sat;
                tbl_wr_data.hcnt  = (rec.hcnt == 2'd3) ? 2'd3 : rec.hcnt + 2'd1;
                tbl_wr_data.est   = est_new;
                n_state           = ST_IDLE;
            end

            ST_SCAN: begin
                tbl_rd_addr = scan_idx;
                if (r_idx == CNT_W'(ENTRIES)) begin
                    n_state = ST_DONE;
                end else if (r_ready[scan_idx]) begin
                    tbl_ctl.rd_en = 1'b1;
                    n_state       = ST_KEY;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end

            ST_KEY: begin
                n_state = ST_CMP;
                case (r_policy)
                    POL_ARRIVAL: n_key = KEY_W'(rec.arrival);
                    POL_KNOWN:   n_key = KEY_W'(rec.known);
                    POL_EXP:     n_key = rec.est;
                    default: begin
                        case (rec.hcnt)
                            2'd0: n_key = {r_init, 8'd0};
                            2'd1: n_key = {rec.hist2, 8'd0};
                            2'd2: begin
                                if (s2 < 18'sd1) begin
                                    n_key = Q_ONE;
                                end else if (s2[16]) begin
                                    n_key = KEY_MAX;
                                end else begin
                                    n_key = {s2[15:0], 8'd0};
                                end
                            end
                            default: begin
                                if (s3 < 20'sd3) begin
                                    n_key = Q_ONE;
                                end else begin
                                    // (s3 << 8) / 3 by reciprocal
                                    mul_req.en = 1'b1;
                                    mul_req.a  = {s3[18:0], 8'd0};
                                    mul_req.b  = DIV3_MUL;
                                    n_state    = ST_DIV;
                                end
                            end
                        endcase
                    end
                endcase
            end

            ST_DIV: begin
                n_key   = div_key;
                n_state = ST_CMP;
            end

            ST_CMP: begin
                if (better) begin
                    n_found    = 1'b1;
                    n_best     = scan_idx;
                    n_best_key = r_key;
                    n_best_age = cand_age;
                end
                n_idx   = r_idx + CNT_W'(1);
                n_state = ST_SCAN;
            end

            ST_DONE: begin
                if (!(r_out_vld && i_out_stall)) begin
                    n_out_vld          = 1'b1;
                    n_out.found        = r_found;
                    n_out.selected_id  = r_found ? 4'(r_best) : 4'd0;
                    n_out.selected_key = r_found ? r_best_key : '0;
                    if (r_found) begin
                        n_ready[r_best] = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_ord     <= '0;
            r_ready   <= '0;
            r_out_vld <= 1'b0;
            r_policy  <= POL_ARRIVAL;
            r_weight  <= 9'd128;
            r_init    <= 16'd10;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_found   <= n_found;
            r_ord     <= n_ord;
            r_ready   <= n_ready;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY:  r_policy <= t_policy'(i_cfg_data[1:0]);
                    CFG_WEIGHT:  r_weight <= i_cfg_data[8:0];
                    CFG_INITIAL: r_init   <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_best     <= n_best;
        r_best_key <= n_best_key;
        r_best_age <= n_best_age;
        r_key      <= n_key;
        r_acc      <= n_acc;
        r_out      <= n_out;
    end

    // an empty ready set reports entry zero with a zero key
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        (o_out_data.selected_id == 4'd0 && o_out_data.selected_key == '0))
        else $error("empty selection carries nonzero id or key");

    // the chosen entry leaves the ready set when its result is issued
    a_pick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !(r_out_vld && i_out_stall) && r_found) |=>
        !r_ready[$past(r_best)])
        else $error("selected entry still ready");

    // scan index never runs past the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNT_W'(ENTRIES))
        else $error("scan index out of range");

    // each mark ready takes exactly one order stamp
    a_ord_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_item.kind == KIND_READY) |=>
        (r_ord == 16'($past(r_ord) + 16'd1)))
        else $error("order counter did not advance on mark ready");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    // a result is only loaded while the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_out)))
        else $error("pending result overwritten");

endmodule

/* hw/rtl/pbjs_mul.sv */
`timescale 1ns / 1ps
// Shared multiplier with registered product.
// Depends on pbjs_pkg for the request type and widths.
module pbjs_mul
    import pbjs_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/pbjs_table.sv */
`timescale 1ns / 1ps
// Process table memory: one write port, one registered read port.
// Depends on pbjs_pkg; per-entry written bits supply the reset view.
module pbjs_table
    import pbjs_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tbl_ctl                   i_ctl,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  t_rec                       i_wr_data,
    output t_rec                       o_rd_data
);

    t_rec               mem [ENTRIES];
    t_rec               r_rd;
    logic               r_rd_vld;
    logic [ENTRIES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written entry: empty history, default estimate
    always_comb begin
        o_rd_data = r_rd;
        if (!r_rd_vld) begin
            o_rd_data.hcnt = '0;
            o_rd_data.est  = EST_RESET;
        end
    end

endmodule

/* tb/sv/predicted_burst_job_selector_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for predicted_burst_job_selector: directed and random command beats,
// with a built-in predictor of the process table and the pick it returns on each select.
// Depends on pbjs_pkg and the block's RTL only.
module predicted_burst_job_selector_test;
    import pbjs_pkg::*;

    localparam int NPROC        = 16;
    localparam int SETTLE       = 16;      // covers the slowest command that gives no beat
    localparam int TAIL         = 100;     // covers a full select walk with every entry ready
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off for the pressure test
    localparam int LIMIT_CYCLES = 600000;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 190;

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = 2'd0;
    logic [15:0] cfg_data  = 16'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;

    // run control shared by the driver, receiver and checker
    bit          quiet     = 1'b0;   // no idling on either side while set
    bit          hold_req  = 1'b0;   // asks the receiver for one long hold-off
    int          mismatches = 0;
    int          cycle_count = 0;

    // predictor copy of the table and the registers
    t_policy     cfg_policy;
    logic [8:0]  cfg_weight;
    logic [15:0] cfg_init;
    logic        tbl_ready   [NPROC];
    logic [15:0] tbl_arrival [NPROC];
    logic [15:0] tbl_known   [NPROC];
    logic [15:0] tbl_hist    [NPROC][3];   // [2] is the newest burst
    logic [1:0]  tbl_hcnt    [NPROC];
    logic [23:0] tbl_est     [NPROC];
    logic [15:0] tbl_stamp   [NPROC];
    logic [15:0] mark_seq;
    t_out_item   pending_picks[$];

    predicted_burst_job_selector dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [23:0] clip24(longint v);
        return (v > longint'(KEY_MAX)) ? KEY_MAX : v[23:0];
    endfunction

    // Least-squares line through the last bursts, evaluated one step ahead.
    function automatic logic [23:0] regress_key(int e);
        longint s;
        case (tbl_hcnt[e])
            2'd0: return clip24(longint'(cfg_init) << 8);
            2'd1: return clip24(longint'(tbl_hist[e][2]) << 8);
            2'd2: begin
                s = 2 * longint'(tbl_hist[e][2]) - longint'(tbl_hist[e][1]);
                if (s < 1) return Q_ONE;
                return clip24(s << 8);
            end
            default: begin
                s = longint'(tbl_hist[e][1]) + 4 * longint'(tbl_hist[e][2])
                    - 2 * longint'(tbl_hist[e][0]);
                if (s < 3) return Q_ONE;    // floor at 1.0
                return clip24((s << 8) / 3);
            end
        endcase
    endfunction

    function automatic logic [23:0] policy_key(int e);
        case (cfg_policy)
            POL_ARRIVAL: return {8'd0, tbl_arrival[e]};
            POL_KNOWN:   return {8'd0, tbl_known[e]};
            POL_EXP:     return tbl_est[e];
            default:     return regress_key(e);
        endcase
    endfunction

    function automatic void reset_model();
        cfg_policy = POL_ARRIVAL;
        cfg_weight = 9'd128;
        cfg_init   = 16'd10;
        mark_seq   = '0;
        for (int i = 0; i < NPROC; i++) begin
            tbl_ready[i] = 1'b0;
            tbl_hcnt[i]  = '0;
            tbl_est[i]   = EST_RESET;
        end
    endfunction

    // Applies one accepted command; a select queues the pick it must return.
    function automatic void schedule_command(t_in_item c);
        int          id;
        int          best;
        bit          found;
        logic [23:0] k;
        logic [23:0] best_key;
        logic [15:0] age;
        logic [15:0] best_age;
        longint      w;
        longint      est;
        t_out_item   pick;
        id = int'(c.process_id);
        case (t_kind'(c.kind))
            KIND_REGISTER: begin
                tbl_hcnt[id]  = '0;
                tbl_est[id]   = clip24(longint'(cfg_init) << 8);
                tbl_ready[id] = 1'b0;
            end
            KIND_READY: begin
                tbl_arrival[id] = c.arr_time;
                tbl_known[id]   = c.burst_length;
                tbl_ready[id]   = 1'b1;
                tbl_stamp[id]   = mark_seq;
                mark_seq        = mark_seq + 16'd1;
            end
            KIND_BURST: begin
                w = (cfg_weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(cfg_weight);
                tbl_hist[id][0] = tbl_hist[id][1];
                tbl_hist[id][1] = tbl_hist[id][2];
                tbl_hist[id][2] = c.burst_length;
                if (tbl_hcnt[id] != 2'd3) tbl_hcnt[id] = tbl_hcnt[id] + 2'd1;
                est = (w * (longint'(c.burst_length) << 8)
                       + (longint'(WEIGHT_ONE) - w) * longint'(tbl_est[id])
                       + longint'(ROUND_HALF)) >> 8;
                tbl_est[id] = clip24(est);
            end
            default: begin
                found    = 1'b0;
                best     = 0;
                best_key = '0;
                best_age = '0;
                for (int i = 0; i < NPROC; i++) begin
                    if (tbl_ready[i]) begin
                        k   = policy_key(i);
                        age = mark_seq - tbl_stamp[i];
                        // smaller key wins; on a tie the longest-waiting entry
                        if (!found || k < best_key || (k == best_key && age > best_age)) begin
                            found    = 1'b1;
                            best     = i;
                            best_key = k;
                            best_age = age;
                        end
                    end
                end
                if (found) tbl_ready[best] = 1'b0;
                pick.found        = found;
                pick.selected_id  = found ? best[3:0] : 4'd0;
                pick.selected_key = found ? best_key : '0;
                pending_picks.insert(pending_picks.size(), pick);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver, receiver, checker
    // ------------------------------------------------------------------
    function automatic t_in_item make_cmd(t_kind k, logic [3:0] id,
                                          logic [15:0] arr, logic [15:0] burst);
        t_in_item c;
        c.kind         = k;
        c.process_id   = id;
        c.arr_time     = arr;
        c.burst_length = burst;
        return c;
    endfunction

    // Offers one beat after a random gap and waits until it is taken.
    task automatic send_cmd(t_in_item c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        schedule_command(c);
    endtask

    // Block idle: nothing owed, and the last non-select command has finished.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_picks.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [15:0] v);
        drain();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        case (idx)
            CFG_POLICY:  cfg_policy = t_policy'(v[1:0]);
            CFG_WEIGHT:  cfg_weight = v[8:0];
            CFG_INITIAL: cfg_init   = v;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic flag_error(string msg);
        if (mismatches < 10) $display("%s", msg);
        mismatches++;
    endtask

    // Receiver: random stall before each beat, or one long hold-off on request.
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 15);
            end
            repeat (n) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
            end
            @(negedge i_clk);
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!(rst_n && o_out_valid === 1'b1));
        end
    end

    // Checker: every taken beat against the oldest queued pick.
    initial begin
        t_out_item want;
        t_out_item got;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
                got = o_out_data;
                if (pending_picks.size() == 0) begin
                    flag_error($sformatf("unexpected beat: found=%0b id=%0d key=%0h",
                                         got.found, got.selected_id, got.selected_key));
                end else begin
                    want = pending_picks.pop_front();
                    if (got.found !== want.found || got.selected_id !== want.selected_id
                        || got.selected_key !== want.selected_key)
                        flag_error($sformatf(
                            "mismatch: exp found=%0b id=%0d key=%0h, got %0b %0d %0h",
                            want.found, want.selected_id, want.selected_key,
                            got.found, got.selected_id, got.selected_key));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 7));   // small values breed ties
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Select on an empty ready set right after reset.
    task automatic test_empty_select();
        send_cmd(make_cmd(KIND_SELECT, 4'd9, 16'hFFFF, 16'hFFFF));
    endtask

    // Reset policy: arrival order, extremes and a tie on arrival.
    task automatic test_arrival_order();
        send_cmd(make_cmd(KIND_READY, 4'd3, 16'hFFFF, 16'd0));
        send_cmd(make_cmd(KIND_READY, 4'd5, 16'd0, 16'hFFFF));
        send_cmd(make_cmd(KIND_READY, 4'd7, 16'd0, 16'd7));
        repeat (3) send_cmd(make_cmd(KIND_SELECT, 4'd0, 16'd0, 16'd0));
    endtask

    // Known next burst, with a refresh of an entry that is already ready.
    task automatic test_known_burst();
        set_reg(CFG_POLICY, 16'(POL_KNOWN));
        send_cmd(make_cmd(KIND_READY, 4'd1, 16'd9, 16'hFFFF));
        send_cmd(make_cmd(KIND_READY, 4'd2, 16'd9, 16'd0));
        send_cmd(make_cmd(KIND_READY, 4'd1, 16'd9, 16'd4));
        repeat (2) send_cmd(make_cmd(KIND_SELECT, 4'd15, 16'd0, 16'd0));
    endtask

    // Exponential estimate: weight above one, largest initial estimate.
    task automatic test_exp_estimate();
        set_reg(CFG_POLICY, 16'(POL_EXP));
        set_reg(CFG_WEIGHT, 16'd511);
        set_reg(CFG_INITIAL, 16'hFFFF);
        send_cmd(make_cmd(KIND_REGISTER, 4'd4, 16'd0, 16'd0));
        send_cmd(make_cmd(KIND_REGISTER, 4'd6, 16'd0, 16'd0));
        send_cmd(make_cmd(KIND_BURST, 4'd4, 16'd0, 16'd0));
        send_cmd(make_cmd(KIND_READY, 4'd6, 16'd1, 16'd1));
        send_cmd(make_cmd(KIND_READY, 4'd4, 16'd2, 16'd2));
        repeat (2) send_cmd(make_cmd(KIND_SELECT, 4'd0, 16'd0, 16'd0));
    endtask

    // Regression: falling trend floored at 1.0 against a never-written entry.
    task automatic test_regression();
        set_reg(CFG_POLICY, 16'(POL_REGRESS));
        send_cmd(make_cmd(KIND_REGISTER, 4'd8, 16'd0, 16'd0));
        send_cmd(make_cmd(KIND_BURST, 4'd8, 16'd0, 16'd100));
        send_cmd(make_cmd(KIND_BURST, 4'd8, 16'd0, 16'd10));
        send_cmd(make_cmd(KIND_READY, 4'd9, 16'd0, 16'd0));
        send_cmd(make_cmd(KIND_READY, 4'd8, 16'd0, 16'd0));
        repeat (2) send_cmd(make_cmd(KIND_SELECT, 4'd0, 16'd0, 16'd0));
    endtask

    // Receiver holds off long enough that the result register fills and the
    // input side stalls behind a finished select.
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (10) begin
            send_cmd(make_cmd(KIND_READY, 4'($urandom_range(0, 15)), rand_field(), rand_field()));
            send_cmd(make_cmd(KIND_SELECT, 4'($urandom_range(0, 15)), rand_field(), rand_field()));
        end
    endtask

    // Random command mixes over several register settings.
    task automatic test_random_phases();
        logic [15:0] weights  [PHASES] = '{16'd0, 16'd256, 16'd511, 16'd1, 16'd128, 16'd300};
        logic [15:0] initials [PHASES] = '{16'd0, 16'hFFFF, 16'd10, 16'd1, 16'd500, 16'd200};
        t_policy     policies [PHASES] = '{POL_REGRESS, POL_EXP, POL_KNOWN, POL_ARRIVAL,
                                           POL_REGRESS, POL_EXP};
        int          id_hi    [PHASES] = '{15, 3, 15, 7, 15, 1};
        int          r;
        t_kind       k;
        for (int ph = 0; ph < PHASES; ph++) begin
            set_reg(CFG_POLICY, 16'(policies[ph]));
            set_reg(CFG_WEIGHT, weights[ph]);
            set_reg(CFG_INITIAL, (ph == 4) ? 16'($urandom_range(0, 65535)) : initials[ph]);
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 10)      k = KIND_REGISTER;
                else if (r < 45) k = KIND_READY;
                else if (r < 72) k = KIND_BURST;
                else             k = KIND_SELECT;
                send_cmd(make_cmd(k, 4'($urandom_range(0, id_hi[ph])),
                                  rand_field(), rand_field()));
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (3) @(negedge i_clk);
        rst_n <= 1'b1;

        test_empty_select();
        test_arrival_order();
        test_known_burst();
        test_exp_estimate();
        test_regression();
        test_output_backpressure();
        test_random_phases();

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (pending_picks.size() != 0)
            flag_error($sformatf("%0d picks never returned", pending_picks.size()));

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
